// ===== rtl/pbs_pkg.sv =====
// Shared types and constants for the priority bitmap task scheduler.
// No dependencies; imported by every module of the block.
package pbs_pkg;

    localparam logic [2:0] OP_READY  = 3'd0;
    localparam logic [2:0] OP_DELAY  = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_LOCK   = 3'd3;
    localparam logic [2:0] OP_UNLOCK = 3'd4;
    localparam logic [2:0] OP_START  = 3'd5;

    localparam logic [7:0] LOCK_MAX = 8'd255;

    localparam int CNT_W = 32;

    // per-entry result of the shared decrement unit
    typedef struct packed {
        logic wr_en;
        logic expire;
        logic ready_out;
    } step_res_t;

endpackage

// ===== rtl/pbs_delay_mem.sv =====
// Delay counter store: one write port, one registered read port.
// Depends on pbs_pkg for the counter width.
module pbs_delay_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [pbs_pkg::CNT_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [pbs_pkg::CNT_W-1:0] rdata
);
    import pbs_pkg::*;

    logic [CNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pbs_step_unit.sv =====
// Shared per-entry step: decrements one delay counter and resolves readiness.
// Depends on pbs_pkg for step_res_t and the counter width.
module pbs_step_unit (
    input  logic                      is_tick,
    input  logic                      flag,
    input  logic                      ready_in,
    input  logic [pbs_pkg::CNT_W-1:0] count,
    output logic [pbs_pkg::CNT_W-1:0] new_count,
    output pbs_pkg::step_res_t        res
);
    import pbs_pkg::*;

    logic active;

    assign active        = is_tick && flag;
    assign new_count     = count - CNT_W'(1);
    assign res.wr_en     = active;
    assign res.expire    = active && (new_count == '0);
    assign res.ready_out = ready_in || res.expire;

endmodule

// ===== rtl/priority_bitmap_task_scheduler.sv =====
// Top level of the priority bitmap task scheduler: event sequencer and state.
// Depends on pbs_pkg, pbs_delay_mem and pbs_step_unit.
//
// Usage:
//   Input channel: an event word (op, prio, ticks) is taken at a rising edge
//   where start is high and busy is low.
//   Result channel: one result word per event, shown for exactly one cycle
//   with done high. The receiver cannot stall; the word is gone after that
//   cycle, so it must be captured while done is high.
//
// Timing:
//   make ready, lock, unlock at zero or that leaves the lock held, delay
//   before start, start when already started, and unused op codes: busy
//   stays low, done rises at the accept edge itself, so one event
//   per cycle is possible.
//   delay after start, tick, unlock reaching zero and a start before start:
//   busy is high while the sequencer walks every priority once through the
//   delay counter memory (one read port, one write port) and the shared
//   decrement unit; done is high in the first cycle with busy low.
//   The walk also finds the lowest ready priority, bit by bit.
//
// Reset: rst_n (async, active low) clears the ready bitmap, delayed flags,
// current task, lock count and the started flag. The counter memory is not
// cleared; a counter value is used only while its delayed flag is set, and
// the flag is set only together with a write of that entry.
module priority_bitmap_task_scheduler #(
    parameter int NUM_PRIO = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [4:0]  prio,
    input  logic [31:0] ticks,
    output logic        done,
    output logic        switch_now,
    output logic [4:0]  next_prio,
    output logic [7:0]  lock_count,
    output logic        none_ready
);
    import pbs_pkg::*;

    localparam int PW = $clog2(NUM_PRIO);
    localparam int CW = $clog2(NUM_PRIO + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // architectural state
    logic [NUM_PRIO-1:0] ready_reg, ready_next;
    logic [NUM_PRIO-1:0] flag_reg, flag_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [7:0]          locks_reg, locks_next;
    logic                started_reg, started_next;

    // sequencer
    logic          state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pv_reg, pv_next;       // entry in the process stage
    logic [PW-1:0] pidx_reg, pidx_next;
    logic          found_reg, found_next;
    logic [PW-1:0] best_reg, best_next;
    logic          done_reg, done_next;
    logic          sw_reg, sw_next;

    // memory port
    logic             mem_we;
    logic [PW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [PW-1:0]    mem_raddr;
    logic [CNT_W-1:0] mem_rdata;

    // step unit
    logic [CNT_W-1:0] step_count;
    step_res_t        step_res;

    logic          accept;
    logic [PW-1:0] prio_idx;
    logic          hit;

    assign accept   = start && !busy;
    assign busy     = (state_reg == ST_SCAN);
    assign prio_idx = PW'(prio);
    assign mem_raddr = idx_reg[PW-1:0];

    pbs_delay_mem #(
        .DEPTH (NUM_PRIO),
        .AW    (PW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pbs_step_unit u_step (
        .is_tick   (op_reg == OP_TICK),
        .flag      (flag_reg[pidx_reg]),
        .ready_in  (ready_reg[pidx_reg]),
        .count     (mem_rdata),
        .new_count (step_count),
        .res       (step_res)
    );

    // first ready bit seen so far in the walk
    assign hit = pv_reg && step_res.ready_out && !found_reg;

    always_comb
    begin
        ready_next   = ready_reg;
        flag_next    = flag_reg;
        cur_next     = cur_reg;
        locks_next   = locks_reg;
        started_next = started_reg;
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        pv_next      = 1'b0;
        pidx_next    = pidx_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        done_next    = 1'b0;
        sw_next      = sw_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg;
        mem_wdata    = ticks;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sw_next    = 1'b0;
                    op_next    = op;
                    idx_next   = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                    done_next  = 1'b1;
                    case (op)
                        OP_READY:
                        begin
                            if ({27'd0, prio} < 32'(NUM_PRIO))
                            begin
                                ready_next[prio_idx] = 1'b1;
                            end
                        end
                        OP_DELAY:
                        begin
                            if (started_reg)
                            begin
                                mem_we             = 1'b1;
                                mem_wdata          = (ticks == '0) ? CNT_W'(1) : ticks;
                                flag_next[cur_reg]  = 1'b1;
                                ready_next[cur_reg] = 1'b0;
                                state_next         = ST_SCAN;
                                done_next          = 1'b0;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = ST_SCAN;
                            done_next  = 1'b0;
                        end
                        OP_LOCK:
                        begin
                            if (locks_reg < LOCK_MAX)
                            begin
                                locks_next = locks_reg + 8'd1;
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (locks_reg != 8'd0)
                            begin
                                locks_next = locks_reg - 8'd1;
                                if (locks_reg == 8'd1)
                                begin
                                    state_next = ST_SCAN;
                                    done_next  = 1'b0;
                                end
                            end
                        end
                        OP_START:
                        begin
                            if (!started_reg)
                            begin
                                state_next = ST_SCAN;
                                done_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue stage: read one counter per cycle
                if (idx_reg < CW'(NUM_PRIO))
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[PW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
                // process stage
                if (pv_reg)
                begin
                    if (step_res.wr_en)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pidx_reg;
                        mem_wdata = step_count;
                    end
                    if (step_res.expire)
                    begin
                        flag_next[pidx_reg]  = 1'b0;
                        ready_next[pidx_reg] = 1'b1;
                    end
                    if (hit)
                    begin
                        found_next = 1'b1;
                        best_next  = pidx_reg;
                    end
                    if (pidx_reg == PW'(NUM_PRIO - 1))
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        if (op_reg == OP_START)
                        begin
                            if (found_next)
                            begin
                                started_next = 1'b1;
                                cur_next     = best_next;
                                sw_next      = 1'b1;
                            end
                        end
                        else if (started_reg && (locks_reg == 8'd0) && found_next &&
                                 (best_next != cur_reg))
                        begin
                            cur_next = best_next;
                            sw_next  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg   <= '0;
            flag_reg    <= '0;
            cur_reg     <= '0;
            locks_reg   <= '0;
            started_reg <= 1'b0;
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            sw_reg      <= 1'b0;
        end
        else
        begin
            ready_reg   <= ready_next;
            flag_reg    <= flag_next;
            cur_reg     <= cur_next;
            locks_reg   <= locks_next;
            started_reg <= started_next;
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pv_reg      <= pv_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            sw_reg      <= sw_next;
        end
    end

    // payload-side sequencer registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pidx_reg <= pidx_next;
        best_reg <= best_next;
    end

    // result word reads the settled state during the done cycle
    assign done       = done_reg;
    assign switch_now = done_reg && sw_reg;
    assign next_prio  = 5'(cur_reg);
    assign lock_count = locks_reg;
    assign none_ready = ~|ready_reg;

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while walk in progress");

    a_locks_hold_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && $past(state_reg == ST_SCAN) |-> $stable(locks_reg))
        else $error("lock count changed during walk");

    a_switch_target_ready: assert property (@(posedge clk) disable iff (!rst_n)
        switch_now |-> ready_reg[cur_reg])
        else $error("switch to a task that is not ready");

    a_walk_ends_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (state_next == ST_IDLE) |=> done_reg)
        else $error("walk ended without a result");
`endif

endmodule
